// ===== hw/rtl/harris_corner_response_top_assert.svh =====
// Assertion macros shared by the Harris corner response block.
`ifndef HARRIS_CORNER_RESPONSE_TOP_ASSERT_SVH
`define HARRIS_CORNER_RESPONSE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define HCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hcr_pkg.sv =====
// Types, constants and helper functions shared by the Harris corner response block.
package hcr_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int RING_ROWS = 16;
  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int RING_BITS = $clog2(RING_ROWS);
  localparam int GREY_AW   = COL_BITS + RING_BITS;
  localparam int GREY_DEPTH = RING_ROWS * MAX_WIDTH;

  localparam logic [0:0] OP_PIXEL = 1'b0;
  localparam logic [0:0] OP_DRAIN = 1'b1;

  localparam logic [1:0] REG_K      = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [15:0] K_RESET      = 16'd2621;
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  localparam logic [14:0] WT_CORNER = 15'd2916;
  localparam logic [14:0] WT_EDGE   = 15'd7992;
  localparam logic [14:0] WT_CENTER = 15'd21904;

  // Cycles from the last product step until the response register is settled.
  localparam logic [3:0] FIN_WAIT = 4'd9;

  typedef struct packed {
    logic [0:0] operation;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [42:0] response;
    logic [11:0] row;
    logic [9:0]  column;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       accept;
    logic       cfg_write;
    logic       rd_en;
    logic       rd_first;
    logic       rd_last;
    logic [2:0] wr;
    logic [2:0] wc;
    logic [1:0] ta;
    logic [1:0] tb;
    logic       prod_en;
    logic       prod_first;
    logic [1:0] pa;
    logic [1:0] pb;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic out_free;
  } sts_t;

  // Weight of a 3x3 Gaussian tap, product of the two 1-D taps 54/148/54.
  function automatic logic [14:0] gauss_wt(input logic [1:0] a, input logic [1:0] b);
    logic ca;
    logic cb;
    ca = (a == 2'd1);
    cb = (b == 2'd1);
    if (ca && cb) begin
      return WT_CENTER;
    end else if (ca || cb) begin
      return WT_EDGE;
    end else begin
      return WT_CORNER;
    end
  endfunction

endpackage

// ===== hw/rtl/hcr_ctrl.sv =====
// Controller state machine that sequences the smoothing, product and response steps.
module hcr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          pixel_valid,
  input  logic          cfg_valid,
  input  hcr_pkg::sts_t sts,
  output logic          pixel_ready,
  output logic          cfg_ready,
  output hcr_pkg::cmd_t cmd
);
  import hcr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SMOOTH = 3'd2;
  localparam logic [2:0] S_GAP    = 3'd3;
  localparam logic [2:0] S_PROD   = 3'd4;
  localparam logic [2:0] S_FINAL  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] wr;
  logic [2:0] wc;
  logic [1:0] ta;
  logic [1:0] tb;
  logic [1:0] pa;
  logic [1:0] pb;
  logic [3:0] cnt;
  logic       smooth_last;
  logic       prod_last;

  assign smooth_last = (wr == 3'd4) && (wc == 3'd4) && (ta == 2'd2) && (tb == 2'd2);
  assign prod_last   = (pa == 2'd2) && (pb == 2'd2);

  assign cfg_ready   = (state == S_IDLE);
  assign pixel_ready = (state == S_IDLE) && !cfg_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!cfg_valid && pixel_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = sts.ready ? S_SMOOTH : S_IDLE;
      end
      S_SMOOTH: begin
        if (smooth_last) begin
          state_next = S_GAP;
        end
      end
      S_GAP: begin
        state_next = S_PROD;
      end
      S_PROD: begin
        if (prod_last) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        if (cnt == FIN_WAIT - 4'd1) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wr    <= '0;
      wc    <= '0;
      ta    <= '0;
      tb    <= '0;
      pa    <= '0;
      pb    <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_CHECK) begin
        wr <= '0;
        wc <= '0;
        ta <= '0;
        tb <= '0;
      end else if (state == S_SMOOTH) begin
        if (tb == 2'd2) begin
          tb <= '0;
          if (ta == 2'd2) begin
            ta <= '0;
            if (wc == 3'd4) begin
              wc <= '0;
              wr <= wr + 3'd1;
            end else begin
              wc <= wc + 3'd1;
            end
          end else begin
            ta <= ta + 2'd1;
          end
        end else begin
          tb <= tb + 2'd1;
        end
      end
      if (state == S_GAP) begin
        pa <= '0;
        pb <= '0;
      end else if (state == S_PROD) begin
        if (pb == 2'd2) begin
          pb <= '0;
          pa <= pa + 2'd1;
        end else begin
          pb <= pb + 2'd1;
        end
      end
      if (state == S_FINAL) begin
        cnt <= cnt + 4'd1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.accept     = pixel_valid && pixel_ready;
    cmd.cfg_write  = cfg_valid && cfg_ready;
    cmd.rd_en      = (state == S_SMOOTH);
    cmd.rd_first   = (ta == 2'd0) && (tb == 2'd0);
    cmd.rd_last    = (ta == 2'd2) && (tb == 2'd2);
    cmd.wr         = wr;
    cmd.wc         = wc;
    cmd.ta         = ta;
    cmd.tb         = tb;
    cmd.prod_en    = (state == S_PROD);
    cmd.prod_first = (pa == 2'd0) && (pb == 2'd0);
    cmd.pa         = pa;
    cmd.pb         = pb;
    cmd.emit       = (state == S_EMIT) && sts.out_free;
  end

endmodule

// ===== hw/rtl/hcr_dpath.sv =====
// Datapath: grey line memory, smoothing window, gradient products and response arithmetic.
module hcr_dpath (
  input  logic             clk,
  input  logic             rst,
  input  hcr_pkg::cmd_t    cmd,
  input  hcr_pkg::pixel_t  pixel,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             result_ready,
  output hcr_pkg::sts_t    sts,
  output logic             result_valid,
  output hcr_pkg::result_t result
);
  import hcr_pkg::*;

  // Configuration and frame position.
  logic [15:0] k_q16;
  logic [10:0] image_width;
  logic [11:0] image_height;
  logic [11:0] in_row;
  logic [9:0]  in_col;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic        frame_done;

  logic [10:0] w_eff;
  logic [11:0] h_eff;
  logic [10:0] map_w;
  logic [11:0] map_h;
  logic [12:0] need_r;
  logic [10:0] need_c;
  logic        cfg_hit;
  logic        pix_we;
  logic [10:0] in_col_inc;
  logic [12:0] in_row_inc;
  logic [10:0] out_col_inc;

  // Grey line memory.
  logic [7:0]          grey_mem [GREY_DEPTH];
  logic [7:0]          grey;
  logic [15:0]         grey_sum;
  logic [GREY_AW-1:0]  wa;
  logic [GREY_AW-1:0]  ra;
  logic [7:0]          rdata;
  logic signed [13:0]  rr;
  logic signed [13:0]  rc;
  logic [12:0]         gr;
  logic [12:0]         gc;

  // Smoothing accumulator and window.
  logic        rd_v;
  logic        rd_first;
  logic        rd_last;
  logic [2:0]  rd_wr;
  logic [2:0]  rd_wc;
  logic [1:0]  rd_ta;
  logic [1:0]  rd_tb;
  logic [23:0] acc;
  logic [23:0] acc_sum;
  logic [23:0] acc_round;
  logic [7:0]  win [5][5];

  // Gradient products.
  logic [1:0]         oa;
  logic [1:0]         ob;
  logic [7:0]         s [3][3];
  logic signed [11:0] gv_w;
  logic signed [11:0] gh_w;
  logic signed [10:0] gv;
  logic signed [10:0] gh;
  logic signed [21:0] vv_w;
  logic signed [21:0] hh_w;
  logic signed [21:0] vh_w;
  logic               p1_v;
  logic               p1_first;
  logic [1:0]         p1_a;
  logic [1:0]         p1_b;
  logic [19:0]        p1_vv;
  logic [19:0]        p1_hh;
  logic signed [20:0] p1_vh;
  logic [14:0]        p1_wt;
  logic               p2_v;
  logic               p2_first;
  logic [34:0]        p2_vv;
  logic [34:0]        p2_hh;
  logic signed [36:0] p2_vh;
  logic [36:0]        sa;
  logic [36:0]        sb;
  logic signed [38:0] sc;

  // Response chain.
  logic [20:0]        av;
  logic [20:0]        bv;
  logic signed [22:0] cv;
  logic [21:0]        tr;
  logic [41:0]        ab;
  logic signed [45:0] cc;
  logic [43:0]        tt;
  logic signed [46:0] det;
  logic [37:0]        klo;
  logic [37:0]        khi;
  logic signed [46:0] det4;
  logic [60:0]        ktr;
  logic signed [63:0] x;
  logic [62:0]        mag;
  logic [42:0]        resp;

  function automatic logic [12:0] mirror(input logic signed [13:0] v, input logic [12:0] n);
    logic signed [13:0] av_m;
    logic signed [13:0] nn;
    nn   = signed'({1'b0, n});
    av_m = (v < 14'sd0) ? -v : v;
    if (av_m >= nn) begin
      av_m = (nn <<< 1) - 14'sd2 - av_m;
    end
    return av_m[12:0];
  endfunction

  always_comb begin
    if (image_width < 11'd5) begin
      w_eff = 11'd5;
    end else if (image_width > 11'(MAX_WIDTH)) begin
      w_eff = 11'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height < 12'd5) ? 12'd5 : image_height;
  end

  assign map_w = w_eff - 11'd2;
  assign map_h = h_eff - 12'd2;

  always_comb begin
    if ({1'b0, out_row} + 13'd4 > {1'b0, h_eff} - 13'd1) begin
      need_r = {1'b0, h_eff} - 13'd1;
    end else begin
      need_r = {1'b0, out_row} + 13'd4;
    end
    if ({1'b0, out_col} + 11'd4 > w_eff - 11'd1) begin
      need_c = w_eff - 11'd1;
    end else begin
      need_c = {1'b0, out_col} + 11'd4;
    end
  end

  assign sts.ready = (out_row < map_h) &&
                     (frame_done || ({1'b0, in_row} > need_r) ||
                      (({1'b0, in_row} == need_r) && ({1'b0, in_col} > need_c)));
  assign sts.out_free = !result_valid || result_ready;

  assign cfg_hit     = (cfg_index == REG_K) || (cfg_index == REG_WIDTH) ||
                       (cfg_index == REG_HEIGHT);
  assign pix_we      = cmd.accept && (pixel.operation == OP_PIXEL);
  assign in_col_inc  = {1'b0, in_col} + 11'd1;
  assign in_row_inc  = {1'b0, in_row} + 13'd1;
  assign out_col_inc = {1'b0, out_col} + 11'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_q16        <= K_RESET;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cmd.cfg_write) begin
      unique case (cfg_index)
        REG_K:      k_q16        <= cfg_data;
        REG_WIDTH:  image_width  <= cfg_data[10:0];
        REG_HEIGHT: image_height <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row     <= '0;
      in_col     <= '0;
      out_row    <= '0;
      out_col    <= '0;
      frame_done <= 1'b0;
    end else if (cmd.cfg_write && cfg_hit) begin
      in_row     <= '0;
      in_col     <= '0;
      out_row    <= '0;
      out_col    <= '0;
      frame_done <= 1'b0;
    end else begin
      if (pix_we) begin
        if (frame_done) begin
          out_row <= '0;
          out_col <= '0;
        end
        if (in_col_inc >= w_eff) begin
          in_col <= '0;
          if (in_row_inc >= {1'b0, h_eff}) begin
            in_row     <= '0;
            frame_done <= 1'b1;
          end else begin
            in_row     <= in_row_inc[11:0];
            frame_done <= 1'b0;
          end
        end else begin
          in_col     <= in_col_inc[9:0];
          frame_done <= 1'b0;
        end
      end
      if (cmd.emit) begin
        if (out_col_inc >= map_w) begin
          out_col <= '0;
          out_row <= out_row + 12'd1;
        end else begin
          out_col <= out_col_inc[9:0];
        end
      end
    end
  end

  // Grey conversion and line memory.
  assign grey_sum = 16'(pixel.blue) * 16'd29 + 16'(pixel.green) * 16'd150 +
                    16'(pixel.red) * 16'd77 + 16'd128;
  assign grey = grey_sum[15:8];
  assign wa   = {in_row[RING_BITS-1:0], in_col[COL_BITS-1:0]};

  assign rr = signed'(14'(out_row)) - 14'sd2 + signed'(14'(cmd.wr)) + signed'(14'(cmd.ta));
  assign rc = signed'(14'(out_col)) - 14'sd2 + signed'(14'(cmd.wc)) + signed'(14'(cmd.tb));
  assign gr = mirror(rr, {1'b0, h_eff});
  assign gc = mirror(rc, {2'b0, w_eff});
  assign ra = {gr[RING_BITS-1:0], gc[COL_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (pix_we) begin
      grey_mem[wa] <= grey;
    end
    rdata <= grey_mem[ra];
  end

  // Smoothing: nine weighted reads per window entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_first <= cmd.rd_first;
    rd_last  <= cmd.rd_last;
    rd_wr    <= cmd.wr;
    rd_wc    <= cmd.wc;
    rd_ta    <= cmd.ta;
    rd_tb    <= cmd.tb;
  end

  assign acc_sum   = (rd_first ? 24'd0 : acc) + 24'(gauss_wt(rd_ta, rd_tb)) * 24'(rdata);
  assign acc_round = acc_sum + 24'd32768;

  always_ff @(posedge clk) begin
    if (rd_v) begin
      acc <= acc_sum;
      if (rd_last) begin
        win[rd_wr][rd_wc] <= acc_round[23:16];
      end
    end
  end

  // Gradients at one product position, mirrored at the map borders.
  always_comb begin
    if ((cmd.pa == 2'd0) && (out_row == 12'd0)) begin
      oa = 2'd2;
    end else if ((cmd.pa == 2'd2) && (out_row == map_h - 12'd1)) begin
      oa = 2'd0;
    end else begin
      oa = cmd.pa;
    end
    if ((cmd.pb == 2'd0) && (out_col == 10'd0)) begin
      ob = 2'd2;
    end else if ((cmd.pb == 2'd2) && ({1'b0, out_col} == map_w - 11'd1)) begin
      ob = 2'd0;
    end else begin
      ob = cmd.pb;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s[i][j] = win[3'(oa) + 3'(i)][3'(ob) + 3'(j)];
      end
    end
  end

  assign gv_w = (signed'({4'b0, s[2][0]}) - signed'({4'b0, s[0][0]})) +
                ((signed'({4'b0, s[2][1]}) - signed'({4'b0, s[0][1]})) <<< 1) +
                (signed'({4'b0, s[2][2]}) - signed'({4'b0, s[0][2]}));
  assign gh_w = (signed'({4'b0, s[0][0]}) - signed'({4'b0, s[0][2]})) +
                ((signed'({4'b0, s[1][0]}) - signed'({4'b0, s[1][2]})) <<< 1) +
                (signed'({4'b0, s[2][0]}) - signed'({4'b0, s[2][2]}));
  assign gv   = gv_w[10:0];
  assign gh   = gh_w[10:0];
  assign vv_w = 22'(gv) * 22'(gv);
  assign hh_w = 22'(gh) * 22'(gh);
  assign vh_w = 22'(gv) * 22'(gh);
  assign p1_wt = gauss_wt(p1_a, p1_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p1_v <= cmd.prod_en;
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    p1_first <= cmd.prod_first;
    p1_a     <= cmd.pa;
    p1_b     <= cmd.pb;
    p1_vv    <= vv_w[19:0];
    p1_hh    <= hh_w[19:0];
    p1_vh    <= vh_w[20:0];
    p2_first <= p1_first;
    p2_vv    <= 35'(p1_wt) * 35'(p1_vv);
    p2_hh    <= 35'(p1_wt) * 35'(p1_hh);
    p2_vh    <= 37'(signed'({1'b0, p1_wt})) * 37'(p1_vh);
    if (p2_v) begin
      sa <= (p2_first ? 37'd0 : sa) + 37'(p2_vv);
      sb <= (p2_first ? 37'd0 : sb) + 37'(p2_hh);
      sc <= (p2_first ? 39'sd0 : sc) + 39'(p2_vh);
    end
  end

  // Response chain, one operation per register.
  always_ff @(posedge clk) begin
    av   <= 21'((sa + 37'd32768) >> 16);
    bv   <= 21'((sb + 37'd32768) >> 16);
    cv   <= 23'((sc + 39'sd32768) >>> 16);
    tr   <= 22'((sa + 37'd32768) >> 16) + 22'((sb + 37'd32768) >> 16);
    ab   <= 42'(av) * 42'(bv);
    cc   <= 46'(cv) * 46'(cv);
    tt   <= 44'(tr) * 44'(tr);
    det  <= signed'(47'(ab)) - 47'(cc);
    klo  <= 38'(k_q16) * 38'(tt[21:0]);
    khi  <= 38'(k_q16) * 38'(tt[43:22]);
    det4 <= det;
    ktr  <= 61'({khi, 22'd0}) + 61'(klo);
    x    <= (64'(det4) <<< 16) - signed'(64'(ktr));
    mag  <= x[63] ? 63'(-x) : 63'(x);
    resp <= 43'((mag + 63'd32768) >> 16);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.response <= resp;
      result.row      <= out_row;
      result.column   <= out_col;
      result.last     <= (out_row == map_h - 12'd1) && ({1'b0, out_col} == map_w - 11'd1);
    end
  end

endmodule

// ===== hw/rtl/harris_corner_response_top.sv =====
// Harris corner response: an item either yields no result or yields one result.
// Each response re-smooths a 5x5 window by 225 reads through the single grey read port.
// It then takes 9 product steps, runs the response chain and loads the result register.
// A finished result waits in the output register while the next request is taken.
// Reset is synchronous: control, configuration, positions and valid flags return to their reset values.
// The grey line memory is not cleared by reset.
`include "harris_corner_response_top_assert.svh"

module harris_corner_response_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_ready,
  input  hcr_pkg::pixel_t  pixel,
  output logic             result_valid,
  input  logic             result_ready,
  output hcr_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import hcr_pkg::*;

  // The controller owns sequencing and its counters; the datapath owns the data storage and arithmetic.
  cmd_t cmd;
  sts_t sts;

  hcr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .cfg_valid   (cfg_valid),
    .sts         (sts),
    .pixel_ready (pixel_ready),
    .cfg_ready   (cfg_ready),
    .cmd         (cmd)
  );

  // The datapath converts each pixel request to grey, stores pixel operations,
  // and on a ready position rebuilds the smoothed window, the blurred gradient
  // products and the response.
  hcr_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .pixel        (pixel),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_ready (result_ready),
    .sts          (sts),
    .result_valid (result_valid),
    .result       (result)
  );

  // After a request is taken the controller is busy checking it in the next cycle.
  `HCR_ASSERT_NEXT(a_busy_after_accept, pixel_valid && pixel_ready, !pixel_ready, "ready after accept")

  // A new result is loaded only while the controller is busy with a request.
  `HCR_ASSERT_NOW(a_load_while_busy, $rose(result_valid), $past(!pixel_ready), "result while idle")

endmodule
